FILE: rtl/ddo_pkg.sv
// Shared types, constants and helpers for the differential drive odometry core.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int MUL_W = 33;   // signed operand width of the serial multiplier
  localparam int DIV_W = 52;   // quotient magnitude bits of the serial divider
  localparam int COR_W = 34;   // CORDIC datapath width
  localparam int COR_N = 30;   // CORDIC iterations

  localparam logic [1:0] ACT_CMD   = 2'd0;
  localparam logic [1:0] ACT_POWER = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] CFG_SEP     = 2'd0;
  localparam logic [1:0] CFG_DIAM    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [31:0] SEP_RST     = 32'd15073;
  localparam logic [31:0] DIAM_RST    = 32'd4588;
  localparam logic [23:0] TIMEOUT_RST = 24'd600000;
  localparam logic [23:0] TIMER_MAX   = 24'hFFFFFF;

  localparam logic [31:0] US_PER_S    = 32'd1000000;
  localparam logic [31:0] RAD_TO_BIN  = 32'd683565276;
  localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [COR_W-1:0] Q30_ONE     = 34'sd1073741824;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic               motor_on;
    logic [19:0]        step_time_us;
  } ddo_req_t;

  typedef struct packed {
    logic signed [31:0] left_joint_rate;
    logic signed [31:0] right_joint_rate;
    logic signed [31:0] left_joint_angle;
    logic signed [31:0] right_joint_angle;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        pose_heading;
    logic signed [31:0] twist_linear;
    logic signed [31:0] twist_angular;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } ddo_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (&v[65:31] || ~|v[65:31]) begin
      return v[31:0];
    end else if (v[65]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7FFFFFFF;
    end
  endfunction

  // atan(2^-i) as a binary angle
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  return 30'd536870912;
      5'd1:  return 30'd316933406;
      5'd2:  return 30'd167458907;
      5'd3:  return 30'd85004756;
      5'd4:  return 30'd42667331;
      5'd5:  return 30'd21354465;
      5'd6:  return 30'd10679838;
      5'd7:  return 30'd5340245;
      5'd8:  return 30'd2670163;
      5'd9:  return 30'd1335087;
      5'd10: return 30'd667544;
      5'd11: return 30'd333772;
      5'd12: return 30'd166886;
      5'd13: return 30'd83443;
      5'd14: return 30'd41722;
      5'd15: return 30'd20861;
      5'd16: return 30'd10430;
      5'd17: return 30'd5215;
      5'd18: return 30'd2608;
      5'd19: return 30'd1304;
      5'd20: return 30'd652;
      5'd21: return 30'd326;
      5'd22: return 30'd163;
      5'd23: return 30'd81;
      5'd24: return 30'd41;
      5'd25: return 30'd20;
      5'd26: return 30'd10;
      5'd27: return 30'd5;
      5'd28: return 30'd3;
      5'd29: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

endpackage

FILE: rtl/ddo_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_mul import ddo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [MUL_W-1:0]    a,
  input  logic signed [MUL_W-1:0]    b,
  output logic                       done,
  output logic signed [2*MUL_W-1:0]  p
);

  logic                   busy;
  logic [5:0]             cnt;
  logic                   neg;
  logic [2*MUL_W-1:0]     acc;
  logic [MUL_W-1:0]       bmag;
  logic [MUL_W-1:0]       amag_in;
  logic [MUL_W-1:0]       bmag_in;
  logic [MUL_W:0]         sum;
  logic [2*MUL_W-1:0]     acc_next;

  assign amag_in = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
  assign bmag_in = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);

  assign sum = acc[0] ? ({1'b0, acc[2*MUL_W-1:MUL_W]} + {1'b0, bmag})
                      : {1'b0, acc[2*MUL_W-1:MUL_W]};
  assign acc_next = {sum, acc[MUL_W-1:1]};

  assign p = neg ? -$signed(acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= a[MUL_W-1] ^ b[MUL_W-1];
      acc  <= {{MUL_W{1'b0}}, amag_in};
      bmag <= bmag_in;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

endmodule

FILE: rtl/ddo_div.sv
// Bit-serial restoring divider, signed dividend, unsigned divisor,
// quotient truncated toward zero; one quotient bit per cycle. Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_div import ddo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W:0]   n,
  input  logic [31:0]             d,
  output logic                    done,
  output logic signed [DIV_W:0]   q
);

  logic              busy;
  logic [5:0]        cnt;
  logic              neg;
  logic [DIV_W-1:0]  quo;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [DIV_W:0]    nmag;
  logic [32:0]       r_sh;
  logic [32:0]       r_diff;
  logic              fits;

  assign nmag   = n[DIV_W] ? (DIV_W+1)'(-n) : (DIV_W+1)'(n);
  assign r_sh   = {rem, quo[DIV_W-1]};
  assign r_diff = r_sh - {1'b0, dvs};
  assign fits   = (r_sh >= {1'b0, dvs});

  assign q = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= n[DIV_W];
      quo <= nmag[DIV_W-1:0];
      rem <= '0;
      dvs <= d;
    end else if (busy) begin
      rem <= fits ? r_diff[31:0] : r_sh[31:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/ddo_cordic.sv
// Iterative rotation CORDIC, one micro-rotation per cycle: sin/cos of a
// binary angle in Q1.30. Depends on ddo_pkg for the arctangent table.
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        ang,
  output logic               done,
  output logic signed [31:0] s,
  output logic signed [31:0] c
);

  logic                    busy;
  logic [4:0]              it;
  logic                    flip;
  logic signed [COR_W-1:0] x;
  logic signed [COR_W-1:0] y;
  logic signed [COR_W-1:0] z;
  logic signed [COR_W-1:0] xs;
  logic signed [COR_W-1:0] ys;
  logic signed [COR_W-1:0] at;
  logic                    flip_in;
  logic [31:0]             ang_f;
  logic signed [COR_W-1:0] xc;
  logic signed [COR_W-1:0] yc;
  logic signed [COR_W-1:0] xo;
  logic signed [COR_W-1:0] yo;

  // quadrants two and three are folded by a half turn
  assign flip_in = ang[31] ^ ang[30];
  assign ang_f   = {ang[31] ^ flip_in, ang[30:0]};

  assign xs = x >>> it;
  assign ys = y >>> it;
  assign at = $signed({4'b0, atan_lut(it)});

  always_comb begin
    xc = x;
    yc = y;
    if (x > Q30_ONE)  xc = Q30_ONE;
    if (x < -Q30_ONE) xc = -Q30_ONE;
    if (y > Q30_ONE)  yc = Q30_ONE;
    if (y < -Q30_ONE) yc = -Q30_ONE;
    xo = flip ? -xc : xc;
    yo = flip ? -yc : yc;
  end

  assign c = xo[31:0];
  assign s = yo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        it   <= '0;
      end else if (busy) begin
        it <= it + 5'd1;
        if (it == 5'(COR_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({{(COR_W-32){ang_f[31]}}, ang_f});
    end else if (busy) begin
      if (!z[COR_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

FILE: rtl/diff_drive_odometry_core.sv
// Differential drive odometry core: sequencer, state and configuration.
// Depends on ddo_pkg, ddo_mul, ddo_div and ddo_cordic.
//
//   channel  signals                                  direction
//   req      req_valid, req_ready, req                in  (velocity, power, tick)
//   rsp      rsp_valid, rsp_ready, rsp                out (one per tick)
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in (register writes)
//
// A velocity command runs one serial multiply; a power request is handled in
// the idle state. A tick runs nine serial divides, eleven serial multiplies
// and two CORDIC runs, one at a time, and skips the twist steps when the step
// time is 0 and some divides when diameter or separation is 0. Reset is
// synchronous; it clears the pose, joint angles and speeds and restores config.
// A finished tick waits in the output register; commands are still taken
// while it waits, and a further tick is computed but holds in its last
// step until the output is free.
`timescale 1ns / 1ps

module diff_drive_odometry_core import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  ddo_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output ddo_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CMD     = 5'd1;
  localparam logic [4:0] S_JR_DIV  = 5'd2;
  localparam logic [4:0] S_AN_MUL  = 5'd3;
  localparam logic [4:0] S_AN_DIV  = 5'd4;
  localparam logic [4:0] S_TR_MUL1 = 5'd5;
  localparam logic [4:0] S_TR_MUL2 = 5'd6;
  localparam logic [4:0] S_TR_DIV  = 5'd7;
  localparam logic [4:0] S_DA_DIV  = 5'd8;
  localparam logic [4:0] S_COR1    = 5'd9;
  localparam logic [4:0] S_X_MUL   = 5'd10;
  localparam logic [4:0] S_Y_MUL   = 5'd11;
  localparam logic [4:0] S_H_MUL   = 5'd12;
  localparam logic [4:0] S_TL_MUL  = 5'd13;
  localparam logic [4:0] S_TL_DIV  = 5'd14;
  localparam logic [4:0] S_TA_MUL  = 5'd15;
  localparam logic [4:0] S_TA_DIV  = 5'd16;
  localparam logic [4:0] S_COR2    = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [4:0]  state;
  logic        launched;

  logic [31:0] sep;
  logic [31:0] diam;
  logic [23:0] timeout;

  logic signed [31:0] lspd, rspd;
  logic               motor_en;
  logic [23:0]        timer;
  logic [31:0]        lang, rang, xacc, yacc, hacc;

  logic [19:0]        dt;
  logic signed [31:0] lin, angv;
  logic               side;
  logic signed [31:0] wl, wr, spd, dr, da, tl, ta, sn, cs;
  logic signed [33:0] d1, d2;

  logic                      mul_start, mul_done;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic                      div_start, div_done;
  logic signed [DIV_W:0]     div_n;
  logic [31:0]               div_d;
  logic signed [DIV_W:0]     div_q;
  logic                      cor_start, cor_done;
  logic [31:0]               cor_ang;
  logic signed [31:0]        cor_s, cor_c;
  logic                      skip;

  logic signed [31:0]        spd_side, w_side;
  logic signed [2*MUL_W-1:0] p_sh17, p_sh16, p_sh30, lin_e, q_e;
  logic signed [34:0]        dsum, ddiff, dsum_adj, dhalf;
  logic [24:0]               tsum;
  logic [23:0]               tnew;
  logic                      req_acc;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_acc   = req_valid && req_ready;

  assign spd_side = side ? rspd : lspd;
  assign w_side   = side ? wr : wl;
  assign p_sh17   = mul_p >>> 17;
  assign p_sh16   = mul_p >>> 16;
  assign p_sh30   = mul_p >>> 30;
  assign lin_e    = $signed({{34{lin[31]}}, lin});
  assign q_e      = $signed({{(2*MUL_W-DIV_W-1){div_q[DIV_W]}}, div_q});
  assign dsum     = $signed({d1[33], d1}) + $signed({d2[33], d2});
  assign ddiff    = $signed({d2[33], d2}) - $signed({d1[33], d1});
  // halve toward zero
  assign dsum_adj = dsum + $signed({34'b0, dsum[34]});
  assign dhalf    = dsum_adj >>> 1;

  assign tsum = {1'b0, timer} + {5'b0, req.step_time_us};
  assign tnew = tsum[24] ? TIMER_MAX : tsum[23:0];

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    skip      = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = US_PER_S;
    cor_ang   = hacc;
    case (state)
      S_CMD: begin
        mul_start = !launched;
        mul_a = {angv[31], angv};
        mul_b = {1'b0, sep};
      end
      S_JR_DIV: begin
        skip = (diam == 32'd0);
        div_start = !launched && !skip;
        div_n = {{4{spd_side[31]}}, spd_side, 17'b0};
        div_d = diam;
      end
      S_AN_MUL: begin
        mul_start = !launched;
        mul_a = {w_side[31], w_side};
        mul_b = {13'b0, dt};
      end
      S_AN_DIV, S_TR_DIV: begin
        div_start = !launched;
        div_n = mul_p[DIV_W:0];
      end
      S_TR_MUL1: begin
        mul_start = !launched;
        mul_a = {w_side[31], w_side};
        mul_b = {1'b0, diam};
      end
      S_TR_MUL2: begin
        mul_start = !launched;
        mul_a = {spd[31], spd};
        mul_b = {13'b0, dt};
      end
      S_DA_DIV: begin
        skip = (sep == 32'd0);
        div_start = !launched && !skip;
        div_n = {{2{ddiff[34]}}, ddiff, 16'b0};
        div_d = sep;
      end
      S_COR1: begin
        cor_start = !launched;
      end
      S_X_MUL: begin
        mul_start = !launched;
        mul_a = {dr[31], dr};
        mul_b = {cs[31], cs};
      end
      S_Y_MUL: begin
        mul_start = !launched;
        mul_a = {dr[31], dr};
        mul_b = {sn[31], sn};
      end
      S_H_MUL: begin
        mul_start = !launched;
        mul_a = {da[31], da};
        mul_b = {1'b0, RAD_TO_BIN};
      end
      S_TL_MUL: begin
        skip = (dt == 20'd0);
        mul_start = !launched && !skip;
        mul_a = {dr[31], dr};
        mul_b = {1'b0, US_PER_S};
      end
      S_TA_MUL: begin
        mul_start = !launched;
        mul_a = {da[31], da};
        mul_b = {1'b0, US_PER_S};
      end
      S_TL_DIV, S_TA_DIV: begin
        div_start = !launched;
        div_n = mul_p[DIV_W:0];
        div_d = {12'b0, dt};
      end
      S_COR2: begin
        cor_start = !launched;
        cor_ang = {1'b0, hacc[31:1]};
      end
      default: begin
      end
    endcase
  end

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ang   (cor_ang),
    .done  (cor_done),
    .s     (cor_s),
    .c     (cor_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sep     <= SEP_RST;
      diam    <= DIAM_RST;
      timeout <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEP:     sep     <= cfg_data;
        CFG_DIAM:    diam    <= cfg_data;
        CFG_TIMEOUT: timeout <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      rsp_valid <= 1'b0;
      lspd      <= '0;
      rspd      <= '0;
      motor_en  <= 1'b0;
      timer     <= TIMER_MAX;
      lang      <= '0;
      rang      <= '0;
      xacc      <= '0;
      yacc      <= '0;
      hacc      <= '0;
      side      <= 1'b0;
    end else begin
      if (mul_start || div_start || cor_start) begin
        launched <= 1'b1;
      end
      if (rsp_valid && rsp_ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            case (req.action)
              ACT_CMD: begin
                lin   <= req.linear_velocity;
                angv  <= req.angular_velocity;
                timer <= '0;
                state <= S_CMD;
              end
              ACT_POWER: begin
                motor_en <= req.motor_on;
              end
              ACT_TICK: begin
                dt    <= req.step_time_us;
                timer <= tnew;
                if (tnew > timeout || !motor_en) begin
                  lspd <= '0;
                  rspd <= '0;
                end
                side  <= 1'b0;
                state <= S_JR_DIV;
              end
              default: begin
              end
            endcase
          end
        end
        S_CMD: begin
          if (mul_done) begin
            launched <= 1'b0;
            lspd  <= sat32(lin_e - p_sh17);
            rspd  <= sat32(lin_e + p_sh17);
            state <= S_IDLE;
          end
        end
        S_JR_DIV: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            if (side) wr <= skip ? 32'sd0 : sat32(q_e);
            else      wl <= skip ? 32'sd0 : sat32(q_e);
            state <= side ? S_AN_MUL : S_JR_DIV;
            side  <= ~side;
          end
        end
        S_AN_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            state    <= S_AN_DIV;
          end
        end
        S_AN_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            if (side) rang <= rang + div_q[31:0];
            else      lang <= lang + div_q[31:0];
            state <= S_TR_MUL1;
          end
        end
        S_TR_MUL1: begin
          if (mul_done) begin
            launched <= 1'b0;
            spd   <= sat32(p_sh17);
            state <= S_TR_MUL2;
          end
        end
        S_TR_MUL2: begin
          if (mul_done) begin
            launched <= 1'b0;
            state    <= S_TR_DIV;
          end
        end
        S_TR_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            if (side) d2 <= div_q[33:0];
            else      d1 <= div_q[33:0];
            state <= side ? S_DA_DIV : S_AN_MUL;
            side  <= ~side;
          end
        end
        S_DA_DIV: begin
          if (skip || div_done) begin
            launched <= 1'b0;
            dr    <= sat32($signed({{31{dhalf[34]}}, dhalf}));
            da    <= skip ? 32'sd0 : sat32(q_e);
            state <= S_COR1;
          end
        end
        S_COR1: begin
          if (cor_done) begin
            launched <= 1'b0;
            sn    <= cor_s;
            cs    <= cor_c;
            state <= S_X_MUL;
          end
        end
        S_X_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            xacc  <= xacc + p_sh30[31:0];
            state <= S_Y_MUL;
          end
        end
        S_Y_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            yacc  <= yacc + p_sh30[31:0];
            state <= S_H_MUL;
          end
        end
        S_H_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            hacc  <= hacc + p_sh16[31:0];
            state <= S_TL_MUL;
          end
        end
        S_TL_MUL: begin
          if (skip) begin
            tl    <= '0;
            ta    <= '0;
            state <= S_COR2;
          end else if (mul_done) begin
            launched <= 1'b0;
            state    <= S_TL_DIV;
          end
        end
        S_TL_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            tl    <= sat32(q_e);
            state <= S_TA_MUL;
          end
        end
        S_TA_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            state    <= S_TA_DIV;
          end
        end
        S_TA_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            ta    <= sat32(q_e);
            state <= S_COR2;
          end
        end
        S_COR2: begin
          if (cor_done) begin
            launched <= 1'b0;
            sn    <= cor_s;
            cs    <= cor_c;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
      rsp.left_joint_rate   <= wl;
      rsp.right_joint_rate  <= wr;
      rsp.left_joint_angle  <= lang;
      rsp.right_joint_angle <= rang;
      rsp.pose_x            <= xacc;
      rsp.pose_y            <= yacc;
      rsp.pose_heading      <= hacc;
      rsp.twist_linear      <= tl;
      rsp.twist_angular     <= ta;
      rsp.quat_z            <= sn;
      rsp.quat_w            <= cs;
    end
  end

endmodule

FILE: tb/diff_drive_odometry_core_tb.sv
// Self-checking bench for diff_drive_odometry_core: directed table, config extremes, then random
// traffic, every tick result checked against a fixed-point predictor or typed-in values. Depends on ddo_pkg.
`timescale 1ns / 1ps

module diff_drive_odometry_core_tb;
  import ddo_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action, block ignores it
  localparam logic [1:0] CFG_NONE = 2'd3;   // index past the register list
  localparam int DRAIN_CYC = 1200;          // a bit more than one tick
  localparam longint CYC_LIMIT = 8000000;

  logic clk, rst;
  logic req_valid, req_ready;
  ddo_req_t req;
  logic rsp_valid, rsp_ready;
  ddo_rsp_t rsp;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  diff_drive_odometry_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [31:0] sep_r, diam_r;
  logic [23:0] tmo_r;
  longint left_spd, right_spd;
  logic motor_en;
  longint since_cmd;
  logic [31:0] left_ang, right_ang, x_pos, y_pos, heading;

  ddo_rsp_t odo_q[$];
  int errors = 0;
  longint cycles = 0;

  const longint atan_q[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                  output longint c);
    logic [31:0] a;
    logic flip;
    longint x, y, z, t;
    a = ang + 32'h40000000;
    flip = a[31];
    a = flip ? ang - 32'h80000000 : ang;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= atan_q[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += atan_q[i];
      end
      x = t;
    end
    if (x > 1073741824) x = 1073741824;
    if (x < -1073741824) x = -1073741824;
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint wheel_rate(longint v);
    if (diam_r == 0) return 0;
    return clamp32((v * 131072) / longint'(diam_r));
  endfunction

  function automatic longint wheel_dist(longint w, longint dt);
    longint spd;
    spd = clamp32((w * longint'(diam_r)) >>> 17);
    return spd * dt / 1000000;
  endfunction

  function automatic void odo_reset();
    sep_r = SEP_RST; diam_r = DIAM_RST; tmo_r = TIMEOUT_RST;
    left_spd = 0; right_spd = 0; motor_en = 0;
    since_cmd = longint'(TIMER_MAX);
    left_ang = 0; right_ang = 0; x_pos = 0; y_pos = 0; heading = 0;
  endfunction

  // advance the predictor by one accepted request; returns 1 with a result on a tick
  function automatic bit odo_step(input ddo_req_t r, output ddo_rsp_t o);
    longint lin, ang, half, dt, wl, wr, d1, d2, dr, da, s, c, tl, ta, hs;
    o = '0;
    tl = 0; ta = 0;
    case (r.action)
      ACT_CMD: begin
        lin = longint'(r.linear_velocity);
        ang = longint'(r.angular_velocity);
        half = (ang * longint'(sep_r)) >>> 17;
        left_spd = clamp32(lin - half);
        right_spd = clamp32(lin + half);
        since_cmd = 0;
        return 0;
      end
      ACT_POWER: begin
        motor_en = r.motor_on;
        return 0;
      end
      ACT_TICK: ;
      default: return 0;
    endcase
    dt = longint'(r.step_time_us);
    since_cmd += dt;
    if (since_cmd > longint'(TIMER_MAX)) since_cmd = longint'(TIMER_MAX);
    if (since_cmd > longint'(tmo_r) || !motor_en) begin
      left_spd = 0; right_spd = 0;
    end
    wl = wheel_rate(left_spd);
    wr = wheel_rate(right_spd);
    left_ang += 32'(wl * dt / 1000000);
    right_ang += 32'(wr * dt / 1000000);
    d1 = wheel_dist(wl, dt);
    d2 = wheel_dist(wr, dt);
    dr = clamp32((d1 + d2) / 2);
    da = (sep_r == 0) ? 0 : clamp32(((d2 - d1) * 65536) / longint'(sep_r));
    sin_cos(heading, s, c);
    x_pos += 32'((dr * c) >>> 30);
    y_pos += 32'((dr * s) >>> 30);
    hs = (da * longint'(RAD_TO_BIN)) >>> 16;
    heading += 32'(hs);
    if (dt != 0) begin
      tl = clamp32(dr * 1000000 / dt);
      ta = clamp32(da * 1000000 / dt);
    end
    sin_cos(heading >> 1, s, c);
    o.left_joint_rate = 32'(wl);
    o.right_joint_rate = 32'(wr);
    o.left_joint_angle = left_ang;
    o.right_joint_angle = right_ang;
    o.pose_x = x_pos;
    o.pose_y = y_pos;
    o.pose_heading = heading;
    o.twist_linear = 32'(tl);
    o.twist_angular = 32'(ta);
    o.quat_z = 32'(s);
    o.quat_w = 32'(c);
    return 1;
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;

  task automatic send_req(input ddo_req_t r, input bit typed, input ddo_rsp_t typed_rsp);
    int gap;
    ddo_rsp_t o;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
    end
    burst_left--;
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1;
    do @(posedge clk); while (!req_ready);
    if (odo_step(r, o)) begin
      if (typed) begin
        // quaternion comes from the predictor, the rest is typed in
        typed_rsp.quat_z = o.quat_z;
        typed_rsp.quat_w = o.quat_w;
        o = typed_rsp;
      end
      odo_q.push_back(o);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 0;
    while (odo_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEP: sep_r = val;
      CFG_DIAM: diam_r = val;
      CFG_TIMEOUT: tmo_r = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic ddo_req_t mk(logic [1:0] a, logic [31:0] lin, logic [31:0] ang,
                                  int mot, int dt);
    ddo_req_t r;
    r.action = a; r.linear_velocity = lin; r.angular_velocity = ang;
    r.motor_on = mot[0]; r.step_time_us = dt[19:0];
    return r;
  endfunction

  function automatic ddo_req_t rand_req();
    ddo_req_t r;
    int pick;
    r = 87'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 50) r.action = ACT_TICK;
    else if (pick < 82) r.action = ACT_CMD;
    else if (pick < 95) r.action = ACT_POWER;
    else r.action = ACT_NONE;
    if ($urandom_range(0, 4) != 0) begin
      r.linear_velocity = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      r.angular_velocity = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
    end
    if (r.action == ACT_POWER) r.motor_on = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 7) != 0) r.step_time_us = 20'($urandom_range(0, 60000));
    return r;
  endfunction

  typedef struct {
    ddo_req_t r;
    bit typed;
    ddo_rsp_t o;
  } row_t;

  row_t plan[$];

  function automatic void add(ddo_req_t r, bit typed = 0);
    row_t w;
    w.r = r; w.typed = typed; w.o = '0;
    plan.push_back(w);
  endfunction

  // receiver: stall pattern changes with the upper bits of a free-running counter
  int rdy_cnt = 0;
  always @(negedge clk) begin
    rdy_cnt <= rdy_cnt + 1;
    case (rdy_cnt[9:8])
      2'd0: rsp_ready <= 1;
      2'd1: rsp_ready <= $urandom_range(0, 1);
      2'd2: rsp_ready <= (rdy_cnt[2:0] == 3'd0);
      default: rsp_ready <= (rdy_cnt[5:0] > 6'd40);
    endcase
  end

  string fname[11] = '{"left_joint_rate", "right_joint_rate", "left_joint_angle",
                       "right_joint_angle", "pose_x", "pose_y", "pose_heading",
                       "twist_linear", "twist_angular", "quat_z", "quat_w"};

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("%0t timeout", $time);
      $display("diff_drive_odometry_core_tb: done, errors");
      $finish;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (odo_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, rsp);
      end else begin
        ddo_rsp_t e;
        logic [351:0] ev, av;
        e = odo_q.pop_front();
        ev = e; av = rsp;
        for (int f = 0; f < 11; f++) begin
          if (ev[351-32*f -: 32] !== av[351-32*f -: 32]) begin
            errors++;
            $display("%0t %s: expected %h, got %h", $time, fname[f],
                     ev[351-32*f -: 32], av[351-32*f -: 32]);
          end
        end
      end
    end
  end

  initial begin
    ddo_rsp_t none;
    none = '0;
    rst = 1;
    req_valid = 0; req = '0;
    cfg_valid = 0; cfg_index = CFG_SEP; cfg_data = '0;
    rsp_ready = 0;
    odo_reset();
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed part: motor off after reset, so the first ticks move nothing
    add(mk(ACT_TICK, 0, 0, 0, 0), 1);
    add(mk(ACT_TICK, 0, 0, 0, 20'hFFFFF), 1);
    add(mk(ACT_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 20'hFFFFF));
    add(mk(ACT_POWER, 0, 0, 1, 0));
    add(mk(ACT_CMD, 32'h7FFFFFFF, 0, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 1000));
    add(mk(ACT_CMD, 32'h80000000, 32'h7FFFFFFF, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 20'hFFFFF));
    add(mk(ACT_CMD, 32'h00020000, 32'h80000000, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 0));
    add(mk(ACT_CMD, 32'h00010000, 32'h00008000, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 20000));
    add(mk(ACT_TICK, 0, 0, 0, 20000));
    add(mk(ACT_TICK, 0, 0, 0, 500000));
    add(mk(ACT_POWER, 0, 0, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 5000));
    add(mk(ACT_POWER, 0, 0, 1, 0));
    add(mk(ACT_CMD, 32'hFFFF0000, 32'h00030000, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 700000));   // past the timeout: speeds cleared
    add(mk(ACT_CMD, 32'h00008000, 32'hFFFF8000, 0, 0));
    add(mk(ACT_TICK, 0, 0, 0, 1));
    foreach (plan[i]) send_req(plan[i].r, plan[i].typed, plan[i].o);

    // config extremes, each followed by a short command/tick sequence
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      case (ph)
        0: write_reg(CFG_DIAM, 0);
        1: begin write_reg(CFG_DIAM, DIAM_RST); write_reg(CFG_SEP, 0); end
        2: begin write_reg(CFG_SEP, SEP_RST); write_reg(CFG_TIMEOUT, 0); end
        3: write_reg(CFG_TIMEOUT, TIMER_MAX);
        4: write_reg(CFG_SEP, 32'hFFFFFFFF);
        5: write_reg(CFG_DIAM, 32'hFFFFFFFF);
        6: begin write_reg(CFG_SEP, 1); write_reg(CFG_DIAM, 1); end
        7: write_reg(CFG_NONE, 32'h12345678);
        default: begin
          write_reg(CFG_SEP, SEP_RST); write_reg(CFG_DIAM, DIAM_RST);
          write_reg(CFG_TIMEOUT, TIMEOUT_RST);
        end
      endcase
      send_req(mk(ACT_POWER, 0, 0, 1, 0), 0, none);
      send_req(mk(ACT_CMD, 32'h00018000, 32'h00014000, 0, 0), 0, none);
      for (int k = 0; k < 3; k++)
        send_req(mk(ACT_TICK, 0, 0, 0, (ph == 3) ? 20'hFFFFF : 20'd30000), 0, none);
    end

    // random phases with new register settings at each boundary
    for (int ph = 0; ph < 8; ph++) begin
      int n;
      wait_idle();
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SEP, $urandom);
        1: write_reg(CFG_SEP, $urandom_range(0, 32'h40000));
        default: write_reg(CFG_SEP, $urandom_range(8000, 30000));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_DIAM, $urandom);
        1: write_reg(CFG_DIAM, $urandom_range(0, 32'h40000));
        default: write_reg(CFG_DIAM, $urandom_range(2000, 10000));
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(CFG_TIMEOUT, $urandom);
      else write_reg(CFG_TIMEOUT, $urandom_range(0, 800000));
      n = 0;
      while (n < 235) begin
        ddo_req_t r;
        r = rand_req();
        send_req(r, 0, none);
        if (r.action != ACT_NONE) n++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("diff_drive_odometry_core_tb: done, clean");
    end else begin
      $display("diff_drive_odometry_core_tb: done, errors");
    end
    $finish;
  end

endmodule
